// File: sv/alignment_tail_trimmer_macros.svh
// Assertion macros used by the alignment tail trimmer checker.
`ifndef ALIGNMENT_TAIL_TRIMMER_MACROS_SVH
`define ALIGNMENT_TAIL_TRIMMER_MACROS_SVH

// Checked only while the block is out of reset.
`define ATT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ATT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/att_pkg.sv
// Package with types and constants of the alignment tail trimmer.
`default_nettype none

package att_pkg;

  localparam int LEN_BITS_DEF  = 16;
  localparam int FIELD_W       = 16;
  localparam int MIN_MATCHES_W = 16;
  localparam int ERR_LIMIT_W   = 17;
  localparam int ERR_FRAC_BITS = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 17;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 64;

  localparam logic [MIN_MATCHES_W-1:0] MIN_MATCHES_RST = 16'd10;
  localparam logic [ERR_LIMIT_W-1:0]   ERR_LIMIT_RST   = 17'd6554;

  typedef enum logic [1:0] {
    OP_MATCH    = 2'd0,
    OP_INSERT   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_MISMATCH = 2'd3
  } edit_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_MATCHES = 1'd0,
    REG_ERROR_LIMIT = 1'd1
  } cfg_reg_t;

  // Input request as it sits in the input register.
  typedef struct packed {
    edit_op_t           op;
    logic               first;
    logic               last;
    logic [FIELD_W-1:0] op_count;
    logic [FIELD_W-1:0] query_len;
    logic [FIELD_W-1:0] target_len;
    logic [FIELD_W-1:0] distance;
  } in_item_t;

endpackage

`default_nettype wire

// File: sv/alignment_tail_trimmer.sv
// A request with tlast goes through the input register and then the result register.
// Throughput: one edit op per cycle save for the stall below; ops before a cut update
// the block counters, and the error-rate multiply-compare is combinational.
// A request waits in the input register only while an unread result blocks the output.
// Reset (rst_n low, synchronous) clears the counters and cut state, empties both
// registers and restores min_matches to 10 and error_limit to 6554.
`default_nettype none

module alignment_tail_trimmer
  import att_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: edit_op[1:0], block_op_count[17:2], block_query_len[33:18],
  // block_target_len[49:34], block_distance[65:50], zero fill [71:66]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: block_first[0]
  input  wire logic [0:0]             in_tuser,
  input  wire logic                   in_tlast,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: kept_ops[15:0], kept_query_len[31:16], kept_target_len[47:32],
  // kept_distance[63:48]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // tuser: keep[0]
  output logic [0:0]                  out_tuser,
  // Configuration writes.
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEN_W  = LEN_BITS + 1;
  localparam int PROD_W = DEN_W + ERR_LIMIT_W;
  localparam logic [LEN_BITS-1:0] RUN_MAX = '1;

  // Configuration registers.
  logic [MIN_MATCHES_W-1:0] min_matches_r;
  logic [ERR_LIMIT_W-1:0]   error_limit_r;

  // Input register.
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;
  logic     s1_go;
  logic     in_accept;

  // Block state.
  logic [LEN_BITS-1:0] ops_left_r, ops_left_nxt;
  logic [LEN_BITS-1:0] query_left_r, query_left_nxt;
  logic [LEN_BITS-1:0] target_left_r, target_left_nxt;
  logic [LEN_BITS-1:0] dist_left_r, dist_left_nxt;
  logic [LEN_BITS-1:0] match_run_r, match_run_nxt;
  logic                cut_found_r, cut_found_nxt;
  logic [LEN_BITS-1:0] cut_ops_r, cut_ops_nxt;
  logic [LEN_BITS-1:0] cut_query_r, cut_query_nxt;
  logic [LEN_BITS-1:0] cut_target_r, cut_target_nxt;
  logic [LEN_BITS-1:0] cut_dist_r, cut_dist_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_keep_r;

  // Working values of the op in the input register.
  logic [LEN_BITS-1:0] ops_b, query_b, target_b, dist_b, run_b;
  logic                found_b;
  logic [LEN_BITS-1:0] op_idx;
  logic [DEN_W-1:0]    denom;
  logic [PROD_W-1:0]   limit_prod;
  logic [PROD_W-1:0]   dist_scaled;
  logic                cut_ok;

  // An op without tlast never waits; one with tlast needs room in the result register.
  assign s1_go     = s1_valid_r && (!s1_item_r.last || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // The first op of a block reloads the counters before it is applied.
  always_comb begin
    if (s1_item_r.first) begin
      ops_b    = LEN_BITS'(s1_item_r.op_count);
      query_b  = LEN_BITS'(s1_item_r.query_len);
      target_b = LEN_BITS'(s1_item_r.target_len);
      dist_b   = LEN_BITS'(s1_item_r.distance);
      run_b    = '0;
      found_b  = 1'b0;
    end else begin
      ops_b    = ops_left_r;
      query_b  = query_left_r;
      target_b = target_left_r;
      dist_b   = dist_left_r;
      run_b    = match_run_r;
      found_b  = cut_found_r;
    end
  end

  always_comb begin
    op_idx          = ops_b - LEN_BITS'(1);
    ops_left_nxt    = ops_b;
    query_left_nxt  = query_b;
    target_left_nxt = target_b;
    dist_left_nxt   = dist_b;
    match_run_nxt   = run_b;
    cut_found_nxt   = found_b;
    if (s1_item_r.first) begin
      cut_ops_nxt    = '0;
      cut_query_nxt  = '0;
      cut_target_nxt = '0;
      cut_dist_nxt   = '0;
    end else begin
      cut_ops_nxt    = cut_ops_r;
      cut_query_nxt  = cut_query_r;
      cut_target_nxt = cut_target_r;
      cut_dist_nxt   = cut_dist_r;
    end

    if (!found_b) begin
      ops_left_nxt = op_idx;
      if (s1_item_r.op == OP_MATCH) begin
        if (run_b != RUN_MAX) begin
          match_run_nxt = run_b + LEN_BITS'(1);
        end
        if (query_b != '0) begin
          query_left_nxt = query_b - LEN_BITS'(1);
        end
        if (target_b != '0) begin
          target_left_nxt = target_b - LEN_BITS'(1);
        end
      end else begin
        match_run_nxt = '0;
        if (s1_item_r.op != OP_DELETE && query_b != '0) begin
          query_left_nxt = query_b - LEN_BITS'(1);
        end
        if (s1_item_r.op != OP_INSERT && target_b != '0) begin
          target_left_nxt = target_b - LEN_BITS'(1);
        end
        if (dist_b != '0) begin
          dist_left_nxt = dist_b - LEN_BITS'(1);
        end
      end
    end

    // Exact test of distance / (target + run) <= error_limit / 2^16.
    denom       = DEN_W'(target_left_nxt) + DEN_W'(match_run_nxt);
    limit_prod  = PROD_W'(error_limit_r) * PROD_W'(denom);
    dist_scaled = PROD_W'({dist_left_nxt, {ERR_FRAC_BITS{1'b0}}});
    cut_ok      = !found_b && (match_run_nxt >= min_matches_r) && (denom != '0) &&
                  (dist_scaled <= limit_prod);

    if (cut_ok) begin
      cut_found_nxt  = 1'b1;
      cut_ops_nxt    = op_idx + match_run_nxt;
      cut_query_nxt  = query_left_nxt + match_run_nxt;
      cut_target_nxt = target_left_nxt + match_run_nxt;
      cut_dist_nxt   = dist_left_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_item_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_matches_r <= MIN_MATCHES_RST;
      error_limit_r <= ERR_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_MATCHES: min_matches_r <= MIN_MATCHES_W'(cfg_wdata);
        REG_ERROR_LIMIT: error_limit_r <= ERR_LIMIT_W'(cfg_wdata);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      ops_left_r    <= '0;
      query_left_r  <= '0;
      target_left_r <= '0;
      dist_left_r   <= '0;
      match_run_r   <= '0;
      cut_found_r   <= 1'b0;
      cut_ops_r     <= '0;
      cut_query_r   <= '0;
      cut_target_r  <= '0;
      cut_dist_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        ops_left_r    <= ops_left_nxt;
        query_left_r  <= query_left_nxt;
        target_left_r <= target_left_nxt;
        dist_left_r   <= dist_left_nxt;
        match_run_r   <= match_run_nxt;
        cut_found_r   <= cut_found_nxt;
        cut_ops_r     <= cut_ops_nxt;
        cut_query_r   <= cut_query_nxt;
        cut_target_r  <= cut_target_nxt;
        cut_dist_r    <= cut_dist_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.op         <= edit_op_t'(in_tdata[1:0]);
      s1_item_r.first      <= in_tuser[0];
      s1_item_r.last       <= in_tlast;
      s1_item_r.op_count   <= in_tdata[17:2];
      s1_item_r.query_len  <= in_tdata[33:18];
      s1_item_r.target_len <= in_tdata[49:34];
      s1_item_r.distance   <= in_tdata[65:50];
    end
    if (s1_go && s1_item_r.last) begin
      out_keep_r <= cut_found_nxt;
      if (cut_found_nxt) begin
        out_data_r <= {FIELD_W'(cut_dist_nxt), FIELD_W'(cut_target_nxt),
                       FIELD_W'(cut_query_nxt), FIELD_W'(cut_ops_nxt)};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_keep_r;

endmodule

`default_nettype wire

// File: sv/att_checker.sv
// Port-level checker for the alignment tail trimmer, bound to the top level.
`default_nettype none

`include "alignment_tail_trimmer_macros.svh"

module att_checker
  import att_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tlast,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]             out_tuser
);

  logic in_fire_last;

  assign in_fire_last = in_tvalid && in_tready && in_tlast;

  `ATT_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "result valid after reset")

  `ATT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `ATT_ASSERT(a_reject_zero, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "rejected block with nonzero lengths")

  `ATT_ASSERT(a_last_gives_result, in_fire_last |-> ##2 out_tvalid, "no result two cycles after a last request")

  `ATT_ASSERT(a_result_from_last, $rose(out_tvalid) |-> $past(in_fire_last, 2), "result without a last request")

endmodule

bind alignment_tail_trimmer att_checker u_att_checker (.*);

`default_nettype wire
